>>> src/rfhp_pkg.sv
// ----------------------------------------------------------------------------
// RGBA float packer package
// Shared types, constants and the binary16 conversion function.
// ----------------------------------------------------------------------------
`default_nettype none

package rfhp_pkg;

    localparam int NUM_CH = 4;

    localparam logic [15:0] HALF_QNAN = 16'h7e00;
    localparam logic [15:0] HALF_INF  = 16'h7c00;
    localparam logic [31:0] ONE_BITS  = 32'h3f80_0000;

    typedef enum logic {
        FMT_HALF  = 1'b0,
        FMT_UNORM = 1'b1
    } t_fmt;

    typedef struct packed {
        logic        zero;
        logic        sat;
        logic [7:0]  expo;
        logic [31:0] prod;
        logic [15:0] half;
    } t_s1;

    typedef struct packed {
        logic        zero;
        logic        sat;
        logic [24:0] sig;
        logic [7:0]  shamt;
        logic [15:0] half;
    } t_s2;

    function automatic logic [15:0] f_to_half(input logic [31:0] b);
        logic [7:0]         e;
        logic [22:0]        m;
        logic signed [9:0]  h;
        logic [3:0]         sh;
        logic [23:0]        sig;
        logic [24:0]        sum;
        logic [15:0]        r;
        e   = b[30:23];
        m   = b[22:0];
        h   = $signed({2'b00, e}) - 10'sd112;
        sh  = 4'd0;
        sig = 24'd0;
        sum = 25'd0;
        if (e == 8'hff && m != 23'd0) begin
            r = HALF_QNAN;
        end else if (b[31]) begin
            r = 16'h0000;
        end else if (e == 8'hff) begin
            r = HALF_INF;
        end else if (h >= 10'sd31) begin
            r = HALF_INF;
        end else if (h < -10'sd10) begin
            r = 16'h0000;
        end else if (h <= 10'sd0) begin
            sh  = 4'(10'sd1 - h);
            sig = {1'b1, m} >> sh;
            sum = {1'b0, sig} + 25'h0001000;
            r   = 16'(sum >> 13);
        end else begin
            sum = {2'b00, m} + 25'h0001000;
            r   = {1'b0, h[4:0], 10'd0} + 16'(sum >> 13);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/rgba_float_to_half_packer.sv
// ----------------------------------------------------------------------------
// RGBA float to half packer
// Converts four binary32 channels per pixel to binary16 or to unorm8.
// ----------------------------------------------------------------------------
// Channel   Signals                              Transfer
// input     start, busy, i_*_bits                start high and busy low
// result    o_valid, o_*_out                     o_valid high, one cycle
// config    i_cfg_we, i_cfg_data                 i_cfg_we high
//
// One pixel per cycle; each result is registered through the stages listed below.
// Stages: decode and x255 product, single rounding, integer rounding, output.
// busy stays low; the receiver cannot stall, so nothing is held back.
// Reset clears the valid bits and the format register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgba_float_to_half_packer
    import rfhp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_red_bits,
    input  wire logic [31:0] i_green_bits,
    input  wire logic [31:0] i_blue_bits,
    input  wire logic [31:0] i_alpha_bits,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_data,
    output logic             o_valid,
    output logic [15:0]      o_red_out,
    output logic [15:0]      o_green_out,
    output logic [15:0]      o_blue_out,
    output logic [15:0]      o_alpha_out
);

    t_fmt        r_fmt;
    logic        r_v1, r_v2, r_v3, r_vo;
    t_fmt        r_f1, r_f2, r_f3;
    logic [31:0] w_in [NUM_CH];
    t_s1         r_s1 [NUM_CH];
    t_s1         n_s1 [NUM_CH];
    t_s2         r_s2 [NUM_CH];
    t_s2         n_s2 [NUM_CH];
    logic [15:0] r_s3 [NUM_CH];
    logic [15:0] n_s3 [NUM_CH];
    logic [15:0] r_out [NUM_CH];

    assign busy = 1'b0;

    assign w_in[0] = i_red_bits;
    assign w_in[1] = i_green_bits;
    assign w_in[2] = i_blue_bits;
    assign w_in[3] = i_alpha_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_HALF;
        end else if (i_cfg_we) begin
            r_fmt <= t_fmt'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1 <= r_fmt;
        r_f2 <= r_f1;
        r_f3 <= r_f2;
    end

    for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
        logic [23:0] w_sig;
        logic [23:0] w_r0;
        logic        w_g;
        logic        w_st;
        logic [26:0] w_sum;

        always_comb begin
            w_sig              = {1'b1, w_in[c][22:0]};
            n_s1[c].zero       = (w_in[c][30:0] > 31'h7f80_0000) || w_in[c][31]
                                 || (w_in[c][30:23] == 8'd0);
            n_s1[c].sat        = !w_in[c][31] && (w_in[c] >= ONE_BITS);
            n_s1[c].expo       = w_in[c][30:23];
            n_s1[c].prod       = {w_sig, 8'd0} - {8'd0, w_sig};
            n_s1[c].half       = f_to_half(w_in[c]);
        end

        always_comb begin
            if (r_s1[c].prod[31]) begin
                w_r0            = r_s1[c].prod[31:8];
                w_g             = r_s1[c].prod[7];
                w_st            = |r_s1[c].prod[6:0];
                n_s2[c].shamt   = 8'd142 - r_s1[c].expo;
            end else begin
                w_r0            = r_s1[c].prod[30:7];
                w_g             = r_s1[c].prod[6];
                w_st            = |r_s1[c].prod[5:0];
                n_s2[c].shamt   = 8'd143 - r_s1[c].expo;
            end
            n_s2[c].sig  = {1'b0, w_r0} + 25'(w_g && (w_st || w_r0[0]));
            n_s2[c].zero = r_s1[c].zero;
            n_s2[c].sat  = r_s1[c].sat;
            n_s2[c].half = r_s1[c].half;
        end

        always_comb begin
            w_sum = 27'd0;
            if (r_f2 == FMT_HALF) begin
                n_s3[c] = r_s2[c].half;
            end else if (r_s2[c].zero) begin
                n_s3[c] = 16'h0000;
            end else if (r_s2[c].sat) begin
                n_s3[c] = 16'h00ff;
            end else if (r_s2[c].shamt > 8'd25) begin
                n_s3[c] = 16'h0000;
            end else begin
                w_sum   = {2'b00, r_s2[c].sig}
                          + (27'd1 << (r_s2[c].shamt[4:0] - 5'd1));
                w_sum   = w_sum >> r_s2[c].shamt[4:0];
                n_s3[c] = {8'd0, w_sum[7:0]};
            end
        end

        always_ff @(posedge i_clk) begin
            r_s1[c]  <= n_s1[c];
            r_s2[c]  <= n_s2[c];
            r_s3[c]  <= n_s3[c];
            r_out[c] <= r_s3[c];
        end
    end

    assign o_valid     = r_vo;
    assign o_red_out   = r_out[0];
    assign o_green_out = r_out[1];
    assign o_blue_out  = r_out[2];
    assign o_alpha_out = r_out[3];

    logic r_fo;
    always_ff @(posedge i_clk) begin
        r_fo <= r_f3;
    end

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##4 o_valid)
        else $error("result strobe missing four cycles after transfer");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 && !r_v2 && !r_v3 |=> !o_valid)
        else $error("result strobe without a transfer in flight");

    a_unorm_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_fo == FMT_UNORM |-> o_red_out[15:8] == 8'd0
            && o_green_out[15:8] == 8'd0 && o_blue_out[15:8] == 8'd0
            && o_alpha_out[15:8] == 8'd0)
        else $error("unorm8 result with high byte set");

endmodule

`default_nettype wire

>>> tb/rgba_float_to_half_packer_test.sv
// ----------------------------------------------------------------------------
// RGBA float to half packer testbench
// Sends binary32 pixels in both output formats and compares each channel with
// a bit-exact local conversion: half with its rounding and clamps, and unorm8
// with the x255 product rounded to single before the final rounding.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module rgba_float_to_half_packer_test
    import rfhp_pkg::*;
();

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
    } t_pix_out;

    localparam int LATENCY   = 4;
    localparam int MAX_CYCLE = 200000;

    function automatic logic [15:0] half_of(input logic [31:0] b);
        logic [7:0]  e;
        logic [31:0] m;
        logic [31:0] sig;
        int          h;
        e = b[30:23];
        m = {9'd0, b[22:0]};
        h = int'(e) - 112;
        if (e == 8'hff && m != 0) return 16'h7e00;
        if (b[31]) return 16'h0000;
        if (e == 8'hff) return 16'h7c00;
        if (h >= 31) return 16'h7c00;
        if (h < -10) return 16'h0000;
        if (h <= 0) begin
            sig = (m | 32'h0080_0000) >> (1 - h);
            return 16'((sig + 32'h1000) >> 13);
        end
        return 16'((32'(h) << 10) + ((m + 32'h1000) >> 13));
    endfunction

    // exact x255 product, rounded to 24 significant bits, then halves up
    function automatic logic [15:0] unorm_of(input logic [31:0] b);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half_ulp;
        int          k;
        int          msb;
        int          d;
        int          sh;
        if (b[30:0] > 31'h7f80_0000) return 16'd0;
        if (b[31]) return 16'd0;
        if (b >= ONE_BITS) return 16'd255;
        q = (b[30:23] == 0) ? {41'd0, b[22:0]} : {41'd1, b[22:0]};
        k = ((b[30:23] == 0) ? 1 : int'(b[30:23])) - 150;
        q = q * 255;
        msb = 0;
        for (int i = 0; i < 40; i++) if (q[i]) msb = i;
        d = (msb > 23) ? msb - 23 : 0;
        if (d > 0) begin
            rem = q & ((64'd1 << d) - 1);
            half_ulp = 64'd1 << (d - 1);
            q = q >> d;
            if (rem > half_ulp || (rem == half_ulp && q[0])) q = q + 1;
        end
        sh = -(k + d);
        if (sh <= 0) return 16'(q << (-sh));
        if (sh >= 40) return 16'd0;
        return 16'((q + (64'd1 << (sh - 1))) >> sh);
    endfunction

    class pixel_scoreboard;
        t_pix_out pending[$];
        int       errors;
        int       matched;

        task report(input string what, input logic [15:0] got,
                    input logic [15:0] want);
            $display("mismatch %s: got %04h want %04h at %0t", what, got, want, $time);
            errors++;
        endtask

        function void note_pixel(input logic [127:0] px, input t_fmt fmt);
            t_pix_out w;
            logic [15:0] c[4];
            for (int i = 0; i < 4; i++) begin
                logic [31:0] b;
                b = px[127 - 32*i -: 32];
                c[i] = (fmt == FMT_UNORM) ? unorm_of(b) : half_of(b);
            end
            w = {c[0], c[1], c[2], c[3]};
            pending = {pending, w};
        endfunction

        task check_pixel(input t_pix_out got);
            t_pix_out w;
            if (pending.size() == 0) begin
                $display("unexpected result at %0t", $time);
                errors++;
                return;
            end
            w = pending.pop_front();
            matched++;
            if (got.red !== w.red) report("red", got.red, w.red);
            if (got.green !== w.green) report("green", got.green, w.green);
            if (got.blue !== w.blue) report("blue", got.blue, w.blue);
            if (got.alpha !== w.alpha) report("alpha", got.alpha, w.alpha);
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_red_bits = '0;
    logic [31:0] i_green_bits = '0;
    logic [31:0] i_blue_bits = '0;
    logic [31:0] i_alpha_bits = '0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_data = 1'b0;
    logic        o_valid;
    logic [15:0] o_red_out;
    logic [15:0] o_green_out;
    logic [15:0] o_blue_out;
    logic [15:0] o_alpha_out;

    pixel_scoreboard sb = new();
    t_fmt            fmt_shadow = FMT_HALF;
    int              cycle = 0;
    int              sent = 0;

    rgba_float_to_half_packer i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_red_bits   (i_red_bits),
        .i_green_bits (i_green_bits),
        .i_blue_bits  (i_blue_bits),
        .i_alpha_bits (i_alpha_bits),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_alpha_out  (o_alpha_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("timeout after %0d cycles", cycle);
            $display("rgba_float_to_half_packer_test: errors");
            $finish;
        end
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_pixel({i_red_bits, i_green_bits, i_blue_bits, i_alpha_bits},
                              fmt_shadow);
            if (o_valid)
                sb.check_pixel({o_red_out, o_green_out, o_blue_out, o_alpha_out});
            if (i_cfg_we)
                fmt_shadow <= t_fmt'(i_cfg_data);
        end
    end

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) n = 0;
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_pixel(input logic [31:0] r, input logic [31:0] g,
                              input logic [31:0] b, input logic [31:0] a);
        start        <= 1'b1;
        i_red_bits   <= r;
        i_green_bits <= g;
        i_blue_bits  <= b;
        i_alpha_bits <= a;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);
    endtask

    task automatic write_format(input t_fmt f);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= f;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_channel();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 7))
            0, 1: ;
            2: v[30:23] = 8'(101 + $urandom_range(0, 42));
            3: v[30:23] = 8'(100 + $urandom_range(0, 26));
            4: v[30:23] = 8'hff;
            5: v[30:23] = $urandom_range(0, 1) ? 8'h00 : 8'h7e;
            default: v = {1'b0, 8'(110 + $urandom_range(0, 16)), v[22:0]};
        endcase
        if ($urandom_range(0, 15) == 0) v[12:0] = 13'h1000;
        return v;
    endfunction

    logic [31:0] corner[20] = '{
        32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
        32'h7fc0_0000, 32'hffc0_0001, 32'h7f7f_ffff, 32'h3f80_0000,
        32'h477f_e000, 32'h477f_f000, 32'h3880_0000, 32'h387f_f000,
        32'h3380_0000, 32'h3300_0000, 32'h337f_ffff, 32'h0000_0001,
        32'h3eff_ffff, 32'h3f00_0000, 32'h3b00_8081, 32'hffff_ffff
    };

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int f = 0; f < 2; f++) begin
            if (f == 1) write_format(FMT_UNORM);
            for (int i = 0; i < 20; i += 4) begin
                send_pixel(corner[i], corner[i + 1], corner[i + 2], corner[i + 3]);
                idle_gap();
            end
            send_pixel(32'h3f7f_ffff, 32'h3c80_0000, 32'h4000_0000, 32'h0080_0000);
        end
        for (int ph = 0; ph < 4; ph++) begin
            write_format(t_fmt'(ph[0] ? FMT_UNORM : FMT_HALF));
            for (int i = 0; i < 170; i++) begin
                send_pixel(pick_channel(), pick_channel(), pick_channel(),
                           pick_channel());
                idle_gap();
            end
        end
        drain();
        $display("sent %0d pixels, checked %0d results, both output formats",
                 sent, sb.matched);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("rgba_float_to_half_packer_test: clean");
        end else begin
            $display("rgba_float_to_half_packer_test: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
